// ===== sv/bsirqm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsirqm_pkg
// Shared types and constants of the bank switching mapper: the classified
// operation that travels from the front end to the back end, register decode
// codes, fixed banks and mirroring codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bsirqm_pkg;

  // Request kinds on the input channel.
  localparam logic [1:0] KindWrite = 2'd0;
  localparam logic [1:0] KindTick  = 2'd1;
  localparam logic [1:0] KindPrg   = 2'd2;
  localparam logic [1:0] KindChr   = 2'd3;

  // Register decode of addr & 0xE001, packed as {addr[14:13], addr[0]}.
  localparam logic [2:0] RegBankSelect = 3'b000;
  localparam logic [2:0] RegBankData   = 3'b001;
  localparam logic [2:0] RegMirror     = 3'b010;
  localparam logic [2:0] RegSram       = 3'b011;
  localparam logic [2:0] RegIrqLatch   = 3'b100;
  localparam logic [2:0] RegIrqReload  = 3'b101;
  localparam logic [2:0] RegIrqOff     = 3'b110;
  localparam logic [2:0] RegIrqOn      = 3'b111;

  // Scanline window of the IRQ counter.
  localparam logic [9:0] LineFirst   = 10'd20;
  localparam logic [9:0] LineLast    = 10'd260;
  localparam logic [9:0] LineSpecial = 10'd1000;

  // Fixed PRG banks and reset values.
  localparam logic [7:0] PrgFixedSecondLast = 8'h3E;
  localparam logic [7:0] PrgFixedLast       = 8'h3F;
  localparam logic [5:0] PrgReset0          = 6'h3C;
  localparam logic [5:0] PrgReset1          = 6'h3D;

  // Mirroring codes.
  localparam logic [1:0] MirrorVertical   = 2'd0;
  localparam logic [1:0] MirrorHorizontal = 2'd1;
  localparam logic [1:0] MirrorFour       = 2'd2;

  // Configuration register indexes.
  localparam logic CfgChrIsRam   = 1'b0;
  localparam logic CfgFourScreen = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,          // no state change, bank 0
    OP_WR_SEL,
    OP_WR_BANK,
    OP_WR_MIRROR,
    OP_WR_LATCH,
    OP_WR_RELOAD,
    OP_WR_IRQ_OFF,
    OP_WR_IRQ_ON,
    OP_TICK_FIRST,   // counting tick on the first line of the window
    OP_TICK_COUNT,
    OP_PRG,
    OP_CHR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [2:0] slot;
  } op_t;

endpackage

`default_nettype wire

// ===== sv/bank_switch_scanline_irq_mapper.sv =====
// ----------------------------------------------------------------------------
// bank_switch_scanline_irq_mapper
// Cartridge bank switching mapper with a scanline IRQ counter.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while its queue has room and
// returns exactly one result per request, in order. A request is a register
// write, a scanline tick, a CPU PRG lookup or a PPU CHR lookup. The front
// end classifies each request in the cycle it is accepted and places it in a
// short queue; the back end executes the head of the queue against the mapper
// registers and loads the result register. A request therefore passes through
// the queue and then the result register, which holds the result while
// out_ready_i is low. One request per cycle is sustained as long as results
// are taken, since the bank and IRQ registers are updated as each request
// leaves the queue. When the result register is held, the queue absorbs up
// to QueueDepth requests before in_ready_o drops.
// Configuration writes (chr_is_ram at index 0, four_screen at index 1) are
// meant to be made while no request is in flight.
`default_nettype none

module bank_switch_scanline_irq_mapper
  import bsirqm_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic [9:0]  scanline_i,
  input  logic [1:0]  render_enables_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  bank_o,
  output logic [1:0]  mirroring_o,
  output logic        irq_pulse_o
);

  op_t  front_op;
  op_t  head_op;
  logic queue_full;
  logic queue_valid;
  logic queue_pop;

  // The queue takes a request whenever it has room, independent of the
  // result side.
  assign in_ready_o = !queue_full;

  bsirqm_front u_front (
    .kind_i           (kind_i),
    .addr_i           (addr_i),
    .data_i           (data_i),
    .scanline_i       (scanline_i),
    .render_enables_i (render_enables_i),
    .op_o             (front_op)
  );

  bsirqm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_valid_i),
    .push_op_i (front_op),
    .full_o    (queue_full),
    .pop_i     (queue_pop),
    .valid_o   (queue_valid),
    .head_o    (head_op)
  );

  // The back end pops the queue when the result register is free or is
  // being emptied in the same cycle.
  bsirqm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_valid_i  (queue_valid),
    .op_i        (head_op),
    .op_pop_o    (queue_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bank_o      (bank_o),
    .mirroring_o (mirroring_o),
    .irq_pulse_o (irq_pulse_o)
  );

endmodule

`default_nettype wire

// ===== sv/bsirqm_front.sv =====
// ----------------------------------------------------------------------------
// bsirqm_front
// Classifies an incoming request into one operation: register decode,
// scanline window and render gating, lookup slot extraction.
// ----------------------------------------------------------------------------
`default_nettype none

module bsirqm_front
  import bsirqm_pkg::*;
(
  input  logic [1:0]  kind_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic [9:0]  scanline_i,
  input  logic [1:0]  render_enables_i,
  output op_t         op_o
);

  logic [2:0] reg_code;
  logic       in_window;

  assign reg_code  = {addr_i[14:13], addr_i[0]};
  assign in_window = ((scanline_i >= LineFirst) && (scanline_i <= LineLast)) ||
                     (scanline_i == LineSpecial);

  always_comb begin
    op_o.op   = OP_NOP;
    op_o.data = data_i;
    op_o.slot = 3'd0;
    unique case (kind_i)
      KindWrite: begin
        if (addr_i[15]) begin
          unique case (reg_code)
            RegBankSelect: op_o.op = OP_WR_SEL;
            RegBankData:   op_o.op = OP_WR_BANK;
            RegMirror:     op_o.op = OP_WR_MIRROR;
            RegSram:       op_o.op = OP_NOP;
            RegIrqLatch:   op_o.op = OP_WR_LATCH;
            RegIrqReload:  op_o.op = OP_WR_RELOAD;
            RegIrqOff:     op_o.op = OP_WR_IRQ_OFF;
            RegIrqOn:      op_o.op = OP_WR_IRQ_ON;
            default:       op_o.op = OP_NOP;
          endcase
        end
      end
      KindTick: begin
        if (in_window && (render_enables_i == 2'b11)) begin
          op_o.op = (scanline_i == LineFirst) ? OP_TICK_FIRST : OP_TICK_COUNT;
        end
      end
      KindPrg: begin
        // Lookups below the cartridge window map to bank zero.
        if (addr_i[15]) begin
          op_o.op   = OP_PRG;
          op_o.slot = {1'b0, addr_i[14:13]};
        end
      end
      KindChr: begin
        op_o.op   = OP_CHR;
        op_o.slot = addr_i[12:10];
      end
      default: op_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/bsirqm_queue.sv =====
// ----------------------------------------------------------------------------
// bsirqm_queue
// Short first-in first-out queue of classified operations between the front
// end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsirqm_queue
  import bsirqm_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bsirqm_back.sv =====
// ----------------------------------------------------------------------------
// bsirqm_back
// Executes classified operations in order: holds the mapper registers, the
// IRQ counter and the configuration, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsirqm_back
  import bsirqm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic       cfg_data_i,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] bank_o,
  output logic [1:0] mirroring_o,
  output logic       irq_pulse_o
);

  logic       chr_is_ram_q, four_screen_q;
  logic [7:0] bank_select_q, bank_select_d;
  logic [5:0] prg_q [2];
  logic [5:0] prg_d [2];
  logic [7:0] chr_q [8];
  logic [7:0] chr_d [8];
  logic       horiz_mirror_q, horiz_mirror_d;
  logic [7:0] latch_q, latch_d;
  logic [7:0] count_q, count_d;
  logic       irq_on_q, irq_on_d;
  logic       reload_q, reload_d;

  logic       out_valid_q;
  logic [7:0] bank_q, bank_d;
  logic [1:0] mirror_out_q, mirror_out_d;
  logic       pulse_q, pulse_d;

  logic [2:0] chr_slot;
  logic [1:0] prg_slot;
  logic [7:0] chr_bank;

  assign op_pop_o    = op_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign bank_o      = bank_q;
  assign mirroring_o = mirror_out_q;
  assign irq_pulse_o = pulse_q;

  assign chr_slot = op_i.slot ^ {bank_select_q[7], 2'b00};
  assign prg_slot = op_i.slot[1:0] ^ {bank_select_q[6], 1'b0};
  assign chr_bank = chr_is_ram_q ? (chr_q[chr_slot] & 8'h07) : chr_q[chr_slot];

  always_comb begin
    bank_select_d  = bank_select_q;
    prg_d          = prg_q;
    chr_d          = chr_q;
    horiz_mirror_d = horiz_mirror_q;
    latch_d        = latch_q;
    count_d        = count_q;
    irq_on_d       = irq_on_q;
    reload_d       = reload_q;
    bank_d         = 8'd0;
    pulse_d        = 1'b0;

    unique case (op_i.op)
      OP_NOP: ;
      OP_WR_SEL:     bank_select_d = op_i.data;
      OP_WR_BANK: begin
        unique case (bank_select_q[2:0])
          3'd0: begin
            chr_d[0] = {op_i.data[7:1], 1'b0};
            chr_d[1] = {op_i.data[7:1], 1'b1};
          end
          3'd1: begin
            chr_d[2] = {op_i.data[7:1], 1'b0};
            chr_d[3] = {op_i.data[7:1], 1'b1};
          end
          3'd2: chr_d[4] = op_i.data;
          3'd3: chr_d[5] = op_i.data;
          3'd4: chr_d[6] = op_i.data;
          3'd5: chr_d[7] = op_i.data;
          3'd6: prg_d[0] = op_i.data[5:0];
          default: prg_d[1] = op_i.data[5:0];
        endcase
      end
      OP_WR_MIRROR:  horiz_mirror_d = op_i.data[0];
      OP_WR_LATCH:   latch_d = op_i.data;
      OP_WR_RELOAD: begin
        count_d  = 8'd0;
        reload_d = 1'b1;
      end
      OP_WR_IRQ_OFF: irq_on_d = 1'b0;
      OP_WR_IRQ_ON:  irq_on_d = 1'b1;
      OP_TICK_FIRST: begin
        if (irq_on_q) begin
          count_d = {7'd0, reload_q};
        end
      end
      OP_TICK_COUNT: begin
        if (irq_on_q) begin
          if ((count_q == 8'd0) || reload_q) begin
            reload_d = 1'b0;
            count_d  = latch_q;
          end else begin
            count_d = count_q - 8'd1;
          end
          pulse_d = (count_q != 8'd0) && (count_d == 8'd0);
        end
      end
      OP_PRG: begin
        if (op_i.slot[1:0] == 2'd1) begin
          bank_d = {2'b00, prg_q[1]};
        end else if (op_i.slot[1:0] == 2'd3) begin
          bank_d = PrgFixedLast;
        end else begin
          bank_d = (prg_slot == 2'd0) ? {2'b00, prg_q[0]} : PrgFixedSecondLast;
        end
      end
      OP_CHR:        bank_d = chr_bank;
      default: ;
    endcase

    // Mirroring reports the register as it stands after this request.
    if (four_screen_q) begin
      mirror_out_d = MirrorFour;
    end else begin
      mirror_out_d = horiz_mirror_d ? MirrorHorizontal : MirrorVertical;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_is_ram_q  <= 1'b0;
      four_screen_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgChrIsRam:   chr_is_ram_q  <= cfg_data_i;
        CfgFourScreen: four_screen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_select_q  <= 8'd0;
      prg_q[0]       <= PrgReset0;
      prg_q[1]       <= PrgReset1;
      for (int i = 0; i < 8; i++) begin
        chr_q[i] <= 8'(i);
      end
      horiz_mirror_q <= 1'b0;
      latch_q        <= 8'd0;
      count_q        <= 8'd0;
      irq_on_q       <= 1'b0;
      reload_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (op_pop_o) begin
        bank_select_q  <= bank_select_d;
        prg_q          <= prg_d;
        chr_q          <= chr_d;
        horiz_mirror_q <= horiz_mirror_d;
        latch_q        <= latch_d;
        count_q        <= count_d;
        irq_on_q       <= irq_on_d;
        reload_q       <= reload_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      bank_q       <= bank_d;
      mirror_out_q <= mirror_out_d;
      pulse_q      <= pulse_d;
    end
  end

endmodule

`default_nettype wire

// ===== verif/bank_switch_scanline_irq_mapper_tb.sv =====
// ----------------------------------------------------------------------------
// bank_switch_scanline_irq_mapper_tb
// Self-checking testbench for the bank switching mapper with scanline IRQ.
// A shadow copy of the mapper registers predicts the bank, mirroring and IRQ
// pulse of every accepted request. Results are checked in order against it,
// under random idling on both channels and four settings of the
// configuration registers.
// ----------------------------------------------------------------------------

module bank_switch_scanline_irq_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsirqm_pkg::*;

  // The run is short: roughly 1400 requests. The limit leaves a wide margin
  // over the slowest legal run with every stall taken.
  localparam int CycleLimit = 200000;

  // One predicted result, as it leaves the block.
  typedef struct packed {
    logic [7:0] bank;
    logic [1:0] mirr;
    logic       irq;
  } result_t;

  // Shadow of the mapper registers. Each accepted request is run against it
  // and the expected result is queued; results from the block are checked
  // against the head of that queue.
  class mapper_shadow;
    logic       chr_ram;
    logic       four_scr;
    logic [7:0] sel;
    logic [5:0] prg [2];
    logic [7:0] chr [8];
    logic       horiz_mirror;
    logic [7:0] latch;
    logic [7:0] count;
    logic       irq_en;
    logic       reload;
    result_t    pending_results [$];
    int         mismatches;
    int         checked;
    int         effective;
    int         pulses;

    function new();
      chr_ram  = 1'b0;
      four_scr = 1'b0;
      sel      = '0;
      prg[0]   = PrgReset0;
      prg[1]   = PrgReset1;
      for (int i = 0; i < 8; i++) chr[i] = 8'(i);
      horiz_mirror = 1'b0;
      latch    = '0;
      count    = '0;
      irq_en   = 1'b0;
      reload   = 1'b0;
      mismatches = 0;
      checked    = 0;
      effective  = 0;
      pulses     = 0;
    endfunction

    function void take_request(logic [1:0] kind, logic [15:0] addr, logic [7:0] data,
                               logic [9:0] line, logic [1:0] en);
      result_t    r;
      logic [2:0] s;
      logic [2:0] cs;
      logic [1:0] ps;
      logic [7:0] old;
      r.bank = '0;
      r.irq  = 1'b0;
      case (kind)
        KindWrite: begin
          // Writes below 0x8000 do not reach the mapper.
          if (addr[15]) begin
            case ({addr[14:13], addr[0]})
              RegBankSelect: sel = data;
              RegBankData: begin
                s = sel[2:0];
                if (s < 3'd2) begin
                  chr[{1'b0, s[0], 1'b0}] = data & 8'hFE;
                  chr[{1'b0, s[0], 1'b1}] = data | 8'h01;
                end else if (s < 3'd6) begin
                  chr[s + 3'd2] = data;
                end else begin
                  prg[s[0]] = data[5:0];
                end
              end
              RegMirror:    horiz_mirror = data[0];
              RegIrqLatch:  latch = data;
              RegIrqReload: begin
                count  = '0;
                reload = 1'b1;
              end
              RegIrqOff:    irq_en = 1'b0;
              RegIrqOn:     irq_en = 1'b1;
              default:      ;
            endcase
            if ({addr[14:13], addr[0]} != RegSram) effective++;
          end
        end
        KindTick: begin
          if (((line >= LineFirst && line <= LineLast) || line == LineSpecial) &&
              en == 2'b11 && irq_en) begin
            effective++;
            if (line == LineFirst) begin
              // The first line of the window only arms the counter.
              count = {7'd0, reload};
            end else begin
              old = count;
              if (count == 8'd0 || reload) begin
                reload = 1'b0;
                count  = latch;
              end else begin
                count = count - 8'd1;
              end
              r.irq = (old != 8'd0) && (count == 8'd0);
            end
          end
        end
        KindPrg: begin
          effective++;
          if (addr[15]) begin
            ps = addr[14:13];
            if (ps == 2'd1) begin
              r.bank = {2'b00, prg[1]};
            end else if (ps == 2'd3) begin
              r.bank = PrgFixedLast;
            end else begin
              if (sel[6]) ps = ps ^ 2'd2;
              r.bank = (ps == 2'd0) ? {2'b00, prg[0]} : PrgFixedSecondLast;
            end
          end
        end
        default: begin
          effective++;
          cs = addr[12:10] ^ {sel[7], 2'b00};
          r.bank = chr[cs];
          if (chr_ram) r.bank = r.bank & 8'h07;
        end
      endcase
      r.mirr = four_scr ? MirrorFour : (horiz_mirror ? MirrorHorizontal : MirrorVertical);
      if (r.irq) pulses++;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [7:0] bank, logic [1:0] mirr, logic irq);
      result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no request waiting: bank %02h mirroring %0d irq %0b",
                   bank, mirr, irq);
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (e.bank !== bank || e.mirr !== mirr || e.irq !== irq) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: expected bank %02h mirr %0d irq %0b,",
                   checked, e.bank, e.mirr, e.irq,
                   " got bank %02h mirr %0d irq %0b", bank, mirr, irq);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic        cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [15:0] addr;
  logic [7:0]  data;
  logic [9:0]  scanline;
  logic [1:0]  render_en;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  bank;
  logic [1:0]  mirroring;
  logic        irq_pulse;

  mapper_shadow shadow;
  int           idle_pct  = 0;
  int           hold_left = 0;
  int           sent      = 0;
  int           cycle_count;

  bank_switch_scanline_irq_mapper DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .addr_i           (addr),
    .data_i           (data),
    .scanline_i       (scanline),
    .render_enables_i (render_en),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .bank_o           (bank),
    .mirroring_o      (mirroring),
    .irq_pulse_o      (irq_pulse)
  );

  // 20 ns clock, low for the first half period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The result side stalls at random, as often as the current phase asks.
  // A phase with idle_pct of zero never stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      hold_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result is checked against the oldest prediction. Values
  // are sampled at the edge, before any update of that edge lands.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) shadow.check_result(bank, mirroring, irq_pulse);
  end

  // Watchdog: ends the run if the handshakes stop making progress.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run did not finish within %0d cycles", CycleLimit);
    $display("*** FAILED ***");
    $finish;
  end

  // Presents one request and holds it until the block takes it. The shadow
  // is updated here, at the edge of acceptance, so that a drain that follows
  // always sees the prediction already queued. After acceptance the sender
  // may drop valid for a short burst.
  task automatic send_request(logic [1:0] k, logic [15:0] a, logic [7:0] d,
                              logic [9:0] l, logic [1:0] e);
    in_valid  <= 1'b1;
    kind      <= k;
    addr      <= a;
    data      <= d;
    scanline  <= l;
    render_en <= e;
    do @(posedge clk); while (!in_ready);
    shadow.take_request(k, a, d, l, e);
    sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Register write: the decode only looks at bits 15, 14:13 and 0, so the
  // bits in between are random.
  task automatic do_write(logic [2:0] code, logic [7:0] d);
    send_request(KindWrite, {1'b1, code[2:1], 12'($urandom), code[0]}, d,
                 10'($urandom), 2'($urandom));
  endtask

  task automatic do_tick(logic [9:0] l, logic [1:0] e);
    send_request(KindTick, 16'($urandom), 8'($urandom), l, e);
  endtask

  task automatic do_lookup(logic [1:0] k, logic [15:0] a);
    send_request(k, a, 8'($urandom), 10'($urandom), 2'($urandom));
  endtask

  // Stops sending and waits until every predicted result has been taken, then
  // lets the two stage pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both configuration registers, one per cycle, while the block is
  // idle.
  task automatic apply_cfg(logic ram, logic four);
    cfg_we    <= 1'b1;
    cfg_index <= CfgChrIsRam;
    cfg_data  <= ram;
    @(posedge clk);
    cfg_index <= CfgFourScreen;
    cfg_data  <= four;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.chr_ram  = ram;
    shadow.four_scr = four;
  endtask

  // One phase of random traffic under a fixed configuration. Most of it is
  // built from short well-formed sequences: a full IRQ setup followed by a
  // run of counting lines, or a bank select followed by its bank data and one
  // to three lookups. Lone writes, lone ticks in and around the window and
  // plain lookups fill the rest. The phase ends once its share of requests has been sent.
  task automatic run_phase(logic ram, logic four, int quota, int idle);
    int goal;
    int pick;
    int n;
    logic [9:0] l;
    settle();
    idle_pct = idle;
    apply_cfg(ram, four);
    goal = sent + quota;
    while (sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        // Small latch values make the counter fire often.
        do_write(RegIrqLatch, ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 5)));
        do_write(RegIrqReload, 8'($urandom));
        do_write(RegIrqOn, 8'($urandom));
        do_tick(LineFirst, 2'b11);
        n = $urandom_range(3, 12);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) == 0)
            do_lookup($urandom_range(0, 1) ? KindPrg : KindChr, 16'($urandom));
          do_tick(LineFirst + 10'(1 + i), ($urandom_range(0, 9) == 0) ? 2'($urandom)
                                                                      : 2'b11);
        end
      end else if (pick < 38) begin
        do_write(RegBankSelect, 8'($urandom));
        do_write(RegBankData, 8'($urandom));
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          do_lookup($urandom_range(0, 1) ? KindPrg : KindChr, 16'($urandom));
      end else if (pick < 48) begin
        do_write(3'($urandom), 8'($urandom));
      end else if (pick < 52) begin
        send_request(KindWrite, {1'b0, 15'($urandom)}, 8'($urandom),
                     10'($urandom), 2'($urandom));
      end else if (pick < 66) begin
        case ($urandom_range(0, 9))
          0:       l = LineFirst;
          1:       l = LineSpecial;
          2:       l = LineLast;
          3:       l = LineLast + 10'd1;
          4:       l = LineFirst - 10'd1;
          5, 6:    l = 10'($urandom);
          default: l = 10'($urandom_range(21, 260));
        endcase
        do_tick(l, ($urandom_range(0, 1) == 0) ? 2'b11 : 2'($urandom));
      end else if (pick < 83) begin
        do_lookup(KindPrg, 16'($urandom));
      end else begin
        do_lookup(KindChr, 16'($urandom));
      end
    end
  endtask

  initial begin
    shadow    = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    kind      = KindWrite;
    addr      = '0;
    data      = '0;
    scanline  = '0;
    render_en = '0;
    out_ready = 1'b0;

    // Reset is asserted at the start and released at a clock edge.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    idle_pct = 20;
    apply_cfg(1'b0, 1'b0);

    // Directed part. Lookups right after reset see the reset banks; a PRG
    // lookup below 0x8000 reads bank 0, and CHR address bits above bit 12
    // are ignored.
    do_lookup(KindPrg, 16'h7FFF);
    do_lookup(KindPrg, 16'h8000);
    do_lookup(KindPrg, 16'hFFFF);
    do_lookup(KindChr, 16'hFFFF);
    // A write below 0x8000 must leave every register as it was.
    send_request(KindWrite, 16'h7FFF, 8'hFF, 10'h3FF, 2'b11);
    // Both swap bits set, bank data goes to PRG register 1.
    do_write(RegBankSelect, 8'hC7);
    do_write(RegBankData, 8'hFF);
    do_lookup(KindPrg, 16'hA000);
    do_lookup(KindPrg, 16'h8000);
    do_lookup(KindChr, 16'h0000);
    // A 2 KB CHR pair: even half cleared, odd half set.
    do_write(RegBankSelect, 8'h00);
    do_write(RegBankData, 8'hFF);
    do_lookup(KindChr, 16'h0400);
    do_write(RegMirror, 8'hFF);
    do_write(RegSram, 8'h00);
    // IRQ: latch of one, reload, enable, then the first line arms the
    // counter, the special line reloads it and the last line makes it fire.
    // Ticks just outside the window, and with one render enable off, do nothing.
    do_write(RegIrqLatch, 8'h01);
    do_write(RegIrqReload, 8'h00);
    do_write(RegIrqOn, 8'h00);
    do_tick(LineFirst - 10'd1, 2'b11);
    do_tick(LineFirst, 2'b11);
    do_tick(LineSpecial, 2'b11);
    do_tick(LineLast, 2'b11);
    do_tick(LineLast + 10'd1, 2'b11);
    do_tick(10'd21, 2'b01);
    do_write(RegIrqOff, 8'h00);
    do_tick(10'd21, 2'b11);

    // Random part over every configuration setting. Each phase starts only
    // once all results of the previous one are in, which also holds the
    // sender back until the block has fully drained. The last phase runs
    // with no idling on either side.
    run_phase(1'b1, 1'b0, 240, 30);
    run_phase(1'b0, 1'b1, 240, 0);
    run_phase(1'b1, 1'b1, 240, 50);
    run_phase(1'b0, 1'b0, 240, 20);
    run_phase(1'b1, 1'b0, 200, 35);
    run_phase(1'b0, 1'b1, 200, 0);

    settle();
    repeat (8) @(posedge clk);

    if (shadow.pending_results.size() != 0) begin
      $display("%0d predicted results never arrived", shadow.pending_results.size());
      shadow.mismatches++;
    end
    $display("Sent %0d requests (%0d with an effect) over four configuration settings;",
             sent, shadow.effective);
    $display("checked %0d results, %0d of them IRQ pulses, with %0d mismatches.",
             shadow.checked, shadow.pulses, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bsirqm_pkg.sv
sv/bsirqm_front.sv
sv/bsirqm_queue.sv
sv/bsirqm_back.sv
sv/bank_switch_scanline_irq_mapper.sv
verif/bank_switch_scanline_irq_mapper_tb.sv
